// ===== hw/rtl/alc_pkg.sv =====
// Shared widths, constants and divider handshake types for the loop recorder.
`timescale 1ns / 1ps
`default_nettype none
package alc_pkg;

  localparam int MAX_LOOP   = 65536;
  localparam int POS_W      = $clog2(MAX_LOOP);
  localparam int LEN_W      = POS_W + 1;
  localparam int BANK_DEPTH = 2 * MAX_LOOP;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 2 * SAMPLE_W;
  localparam int GAIN_W   = 16;
  localparam int CF_W     = 13;
  localparam int CMP_W    = (LEN_W > CF_W) ? LEN_W : CF_W;
  localparam int FRAC_W   = 15;

  // Crossfade numerator: |loop * r + start * (C - r)| stays below 2^28
  localparam int NUM_W = 30;
  localparam int MAG_W = 29;

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(16384);
  localparam logic [CF_W-1:0]   XFADE_RESET = CF_W'(480);
  localparam int ROUND_HALF = 16384;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;

  typedef struct packed {
    logic                       start;
    logic signed [NUM_W-1:0]    num_l;
    logic signed [NUM_W-1:0]    num_r;
    logic        [CF_W-1:0]     den;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quo_l;
    logic signed [SAMPLE_W-1:0] quo_r;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/alc_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module alc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/alc_div.sv =====
// Two-lane restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module alc_div import alc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0]    cnt;
  logic                done;
  logic                neg_l, neg_r;
  logic [MAG_W-1:0]    quo_l, quo_r;
  logic [CF_W-1:0]     rem_l, rem_r;
  logic [CF_W-1:0]     den;
  logic [NUM_W-1:0]    abs_l, abs_r;
  logic [CF_W:0]       sh_l, sh_r;
  logic                fit_l, fit_r;
  logic [SAMPLE_W:0]   q_l, q_r;

  assign abs_l = req.num_l[NUM_W-1] ? NUM_W'(-req.num_l) : req.num_l;
  assign abs_r = req.num_r[NUM_W-1] ? NUM_W'(-req.num_r) : req.num_r;

  // Bring down the next dividend bit and try the subtract
  assign sh_l  = {rem_l, quo_l[MAG_W-1]};
  assign sh_r  = {rem_r, quo_r[MAG_W-1]};
  assign fit_l = sh_l >= {1'b0, den};
  assign fit_r = sh_r >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (req.start) begin
        cnt <= CNT_W'(MAG_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_l <= req.num_l[NUM_W-1];
      neg_r <= req.num_r[NUM_W-1];
      quo_l <= abs_l[MAG_W-1:0];
      quo_r <= abs_r[MAG_W-1:0];
      rem_l <= '0;
      rem_r <= '0;
      den   <= req.den;
    end else if (cnt != '0) begin
      rem_l <= fit_l ? CF_W'(sh_l - {1'b0, den}) : sh_l[CF_W-1:0];
      rem_r <= fit_r ? CF_W'(sh_r - {1'b0, den}) : sh_r[CF_W-1:0];
      quo_l <= {quo_l[MAG_W-2:0], fit_l};
      quo_r <= {quo_r[MAG_W-2:0], fit_r};
    end
  end

  assign q_l = neg_l ? (SAMPLE_W+1)'(-quo_l[SAMPLE_W:0]) : quo_l[SAMPLE_W:0];
  assign q_r = neg_r ? (SAMPLE_W+1)'(-quo_r[SAMPLE_W:0]) : quo_r[SAMPLE_W:0];

  assign rsp.done  = done;
  assign rsp.quo_l = q_l[SAMPLE_W-1:0];
  assign rsp.quo_r = q_r[SAMPLE_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/audio_looper_crossfade_core.sv =====
// Top level of the stereo loop recorder with end-of-loop crossfade.
`timescale 1ns / 1ps
`default_nettype none
// Stereo loop recorder. Each transfer on the slave stream is one Q1.15 frame
// with play and record flags; each frame yields exactly one output frame on the
// master stream. Both sample banks live in one 2 x MAX_LOOP x 32 bit RAM; the
// active bank bit selects which half plays and which half records, so a commit
// (falling edge of record) swaps halves instead of copying. Frames are handled
// one at a time: a plain frame passes through accept, address, RAM read, gain
// multiply and output before the next transfer can be taken. A frame inside
// the crossfade window needs a second RAM read for the loop-start sample and a
// signed divide by crossfade_length in a 29-step bit-serial divider. Record
// writes land in the other bank only in the final cycle, after all reads of
// the frame, so no read can overlap a write to the same entry. The output
// register lets the next frame be accepted while a finished frame still waits
// for m_tready. Bank entries are not cleared after reset; only entries below
// the loop length are ever read, and those were written by the recording that
// set it.
module audio_looper_crossfade_core import alc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // slave stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [FRAME_W-1:0]       s_tdata,   // in_left [15:0], in_right [31:16]
  input  logic [1:0]               s_tuser,   // play [0], record [1]
  // master stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [FRAME_W-1:0]       m_tdata,   // out_left [15:0], out_right [31:16]
  output logic                     m_tlast,   // loop_wrapped
  output logic [0:0]               m_tuser,   // record_full [0]
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [GAIN_W-1:0]        cfg_data
);

  localparam logic [1:0] CFG_INPUT_GAIN = 2'd0;
  localparam logic [1:0] CFG_LOOP_GAIN  = 2'd1;
  localparam logic [1:0] CFG_XFADE_LEN  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR,
    S_FETCH,
    S_XMUL,
    S_XSUM,
    S_XGO,
    S_XDIV,
    S_GAIN,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [GAIN_W-1:0] input_gain;
  logic [GAIN_W-1:0] loop_gain;
  logic [CF_W-1:0]   xfade_len;

  // loop state
  logic              active;
  logic [LEN_W-1:0]  loop_len;
  logic [LEN_W-1:0]  rec_len;
  logic [POS_W-1:0]  rd_pos;
  logic              prev_rec;

  // per-frame registers
  logic signed [SAMPLE_W-1:0] in_l, in_r;
  logic                       play_q, rec_q;
  logic                       mix_on, fade_q;
  logic [POS_W-1:0]           pos_q, start_q;
  logic [LEN_W-1:0]           rem_q;
  logic signed [SAMPLE_W-1:0] f_l, f_r;
  logic signed [SAMPLE_W-1:0] mix_l, mix_r;
  logic signed [NUM_W-1:0]    pa_l, pa_r, pb_l, pb_r;
  logic signed [NUM_W-1:0]    num_l, num_r;
  logic signed [PROD_W-1:0]   acc_in_l, acc_in_r;
  logic signed [PROD_W-1:0]   acc_mix_l, acc_mix_r;

  // memory ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [FRAME_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [FRAME_W-1:0]  ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // position and crossfade decode for the frame in hand
  logic              fade_on;
  logic [POS_W-1:0]  start_c, pos_c;
  logic [LEN_W-1:0]  rem_c;
  logic [CMP_W-1:0]  xf_idx;
  logic [CF_W-1:0]   w_a, w_b;

  // arithmetic operands, extended to the product width
  logic signed [PROD_W-1:0] in_l_w, in_r_w, ig_w, lg_w, mix_l_w, mix_r_w;
  logic signed [NUM_W-1:0]  f_l_w, f_r_w, g_l_w, g_r_w, w_a_w, w_b_w;
  logic signed [ACC_W-1:0]  sum_l, sum_r, sh_l, sh_r;
  logic signed [SAMPLE_W-1:0] out_l_c, out_r_c;

  logic rec_room;
  logic out_free;

  assign fade_on = (xfade_len != '0) && (CMP_W'(xfade_len) < CMP_W'(loop_len));
  assign start_c = fade_on ? POS_W'(xfade_len) : '0;
  assign pos_c   = ({1'b0, rd_pos} >= loop_len) ? start_c : rd_pos;
  assign rem_c   = loop_len - {1'b0, pos_c};

  // index of the loop-start partner frame and the two blend weights
  assign xf_idx = CMP_W'(xfade_len) - CMP_W'(rem_q);
  assign w_a    = CF_W'(rem_q);
  assign w_b    = CF_W'(xf_idx);

  assign in_l_w  = PROD_W'(in_l);
  assign in_r_w  = PROD_W'(in_r);
  assign ig_w    = PROD_W'(input_gain);
  assign lg_w    = PROD_W'(loop_gain);
  assign mix_l_w = PROD_W'(mix_l);
  assign mix_r_w = PROD_W'(mix_r);

  assign f_l_w = NUM_W'(f_l);
  assign f_r_w = NUM_W'(f_r);
  assign g_l_w = NUM_W'($signed(ram_rdata[SAMPLE_W-1:0]));
  assign g_r_w = NUM_W'($signed(ram_rdata[FRAME_W-1:SAMPLE_W]));
  assign w_a_w = NUM_W'(w_a);
  assign w_b_w = NUM_W'(w_b);

  // round half up, then floor by the arithmetic shift
  assign sum_l = ACC_W'(acc_in_l) + ACC_W'(acc_mix_l) + ACC_W'(ROUND_HALF);
  assign sum_r = ACC_W'(acc_in_r) + ACC_W'(acc_mix_r) + ACC_W'(ROUND_HALF);
  assign sh_l  = sum_l >>> FRAC_W;
  assign sh_r  = sum_r >>> FRAC_W;

  always_comb begin
    if (sh_l > ACC_W'(SAT_MAX)) begin
      out_l_c = SAMPLE_W'(SAT_MAX);
    end else if (sh_l < ACC_W'(SAT_MIN)) begin
      out_l_c = SAMPLE_W'(SAT_MIN);
    end else begin
      out_l_c = sh_l[SAMPLE_W-1:0];
    end
    if (sh_r > ACC_W'(SAT_MAX)) begin
      out_r_c = SAMPLE_W'(SAT_MAX);
    end else if (sh_r < ACC_W'(SAT_MIN)) begin
      out_r_c = SAMPLE_W'(SAT_MIN);
    end else begin
      out_r_c = sh_r[SAMPLE_W-1:0];
    end
  end

  assign rec_room = rec_len < LEN_W'(MAX_LOOP);
  assign out_free = !m_tvalid || m_tready;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // play bank is addressed with the active bit, record bank with its inverse
  assign ram_raddr = (state == S_ADDR) ? {active, pos_c} : {active, POS_W'(xf_idx)};
  assign ram_we    = (state == S_OUT) && out_free && rec_q && rec_room;
  assign ram_waddr = {~active, rec_len[POS_W-1:0]};
  assign ram_wdata = {in_r, in_l};

  assign div_req = '{start: (state == S_XGO), num_l: num_l, num_r: num_r, den: xfade_len};

  alc_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (BANK_DEPTH)
  ) u_banks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  alc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain <= GAIN_RESET;
      loop_gain  <= GAIN_RESET;
      xfade_len  <= XFADE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INPUT_GAIN: input_gain <= cfg_data;
        CFG_LOOP_GAIN:  loop_gain  <= cfg_data;
        CFG_XFADE_LEN:  xfade_len  <= cfg_data[CF_W-1:0];
        default: ;
      endcase
    end
  end

  // frame sequencer, loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      active   <= 1'b0;
      loop_len <= '0;
      rec_len  <= '0;
      rd_pos   <= '0;
      prev_rec <= 1'b0;
    end else begin
      // a retiring frame refills the register in the same cycle
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_l   <= $signed(s_tdata[SAMPLE_W-1:0]);
            in_r   <= $signed(s_tdata[FRAME_W-1:SAMPLE_W]);
            play_q <= s_tuser[0];
            rec_q  <= s_tuser[1];
            state  <= S_ADDR;
          end
        end
        S_ADDR: begin
          // read of the play frame is issued this cycle
          mix_on   <= play_q && (loop_len != '0);
          fade_q   <= play_q && (loop_len != '0) && fade_on &&
                      (CMP_W'(rem_c) < CMP_W'(xfade_len));
          pos_q    <= pos_c;
          start_q  <= start_c;
          rem_q    <= rem_c;
          acc_in_l <= in_l_w * ig_w;
          acc_in_r <= in_r_w * ig_w;
          state    <= S_FETCH;
        end
        S_FETCH: begin
          // play frame arrives; loop-start read is issued for a crossfade
          f_l   <= $signed(ram_rdata[SAMPLE_W-1:0]);
          f_r   <= $signed(ram_rdata[FRAME_W-1:SAMPLE_W]);
          mix_l <= $signed(ram_rdata[SAMPLE_W-1:0]);
          mix_r <= $signed(ram_rdata[FRAME_W-1:SAMPLE_W]);
          state <= fade_q ? S_XMUL : S_GAIN;
        end
        S_XMUL: begin
          pa_l  <= f_l_w * w_a_w;
          pa_r  <= f_r_w * w_a_w;
          pb_l  <= g_l_w * w_b_w;
          pb_r  <= g_r_w * w_b_w;
          state <= S_XSUM;
        end
        S_XSUM: begin
          num_l <= pa_l + pb_l;
          num_r <= pa_r + pb_r;
          state <= S_XGO;
        end
        S_XGO: begin
          state <= S_XDIV;
        end
        S_XDIV: begin
          if (div_rsp.done) begin
            mix_l <= div_rsp.quo_l;
            mix_r <= div_rsp.quo_r;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          acc_mix_l <= mix_on ? mix_l_w * lg_w : '0;
          acc_mix_r <= mix_on ? mix_r_w * lg_w : '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free, then retire the frame
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {out_r_c, out_l_c};
            m_tlast    <= mix_on && (rem_q == LEN_W'(1));
            m_tuser[0] <= rec_q && !rec_room;
            // a commit restarts playback instead of advancing it
            if (mix_on && (rec_q || !prev_rec)) begin
              rd_pos <= (rem_q == LEN_W'(1)) ? start_q : POS_W'(pos_q + POS_W'(1));
            end
            if (rec_q) begin
              if (rec_room) begin
                rec_len <= rec_len + LEN_W'(1);
              end
            end else if (prev_rec) begin
              // commit: swap banks and restart playback from the top
              active   <= ~active;
              loop_len <= rec_len;
              rec_len  <= '0;
              rd_pos   <= '0;
            end
            prev_rec <= rec_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the divider answers only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_XDIV))
    else $error("divider result outside the wait state");

  // record writes happen only when a recording frame retires into a free register
  assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (m_tvalid && (state == S_IDLE) && $past(rec_q)))
    else $error("bank write without a retiring record frame");

  // between frames the play position always lies inside a nonempty loop
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && (loop_len != '0)) |-> ({1'b0, rd_pos} < loop_len))
    else $error("play position beyond loop length");

endmodule
`default_nettype wire
